// ===== design/lbp3_pkg.sv =====
// Package for the 3x3 local binary pattern block: field widths, register
// indexes, reset values and the neighbour comparison function.
// No dependencies.
package lbp3_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_OUT_W  = 10;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 1;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4095;
    localparam int MIN_DIM       = 3;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    // Neighbours in code bit order: top-left, top, top-right, left, right,
    // bottom-left, bottom, bottom-right.
    typedef t_pix t_nbrs [8];

    function automatic t_pix lbp_code(input t_pix ctr, input t_nbrs nbr);
        t_pix code;
        code = '0;
        for (int k = 0; k < 8; k++) begin
            code[k] = (nbr[k] > ctr);
        end
        return code;
    endfunction

endpackage

// ===== design/lbp3_line_store.sv =====
// Two line stores (row two above and row one above the input row) with a
// registered read port, one write port and a zeroing sweep after reset.
// Depends on lbp3_pkg.
module lbp3_line_store #(
    parameter int DEPTH = lbp3_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output lbp3_pkg::t_pix       o_rd_upper,
    output lbp3_pkg::t_pix       o_rd_lower,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  lbp3_pkg::t_pix       i_wr_upper,
    input  lbp3_pkg::t_pix       i_wr_lower,
    output logic                 o_busy
);
    import lbp3_pkg::*;

    t_pix r_mem_upper [DEPTH];
    t_pix r_mem_lower [DEPTH];
    t_pix r_rd_upper;
    t_pix r_rd_lower;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_pix          wr_upper;
    t_pix          wr_lower;

    // zeroing sweep, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            wr_en    = 1'b1;
            wr_addr  = r_clr_addr;
            wr_upper = '0;
            wr_lower = '0;
        end else begin
            wr_en    = i_wr_en;
            wr_addr  = i_wr_addr;
            wr_upper = i_wr_upper;
            wr_lower = i_wr_lower;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_upper[wr_addr] <= wr_upper;
            r_mem_lower[wr_addr] <= wr_lower;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_upper <= r_mem_upper[i_rd_addr];
            r_rd_lower <= r_mem_lower[i_rd_addr];
        end
    end

    assign o_rd_upper = r_rd_upper;
    assign o_rd_lower = r_rd_lower;
    assign o_busy     = r_clr_busy;

endmodule

// ===== design/local_binary_pattern_3x3.sv =====
// Top level of the streaming 3x3 local binary pattern block.
// Depends on lbp3_pkg and lbp3_line_store.
//
// Usage:
//   Pixels of an 8-bit gray image enter in raster order on the input
//   channel (i_in_valid / o_in_stall / i_pixel), one per transaction.
//   Each input transaction causes exactly one output transaction
//   (o_out_valid / i_out_stall) carrying the pattern of the pixel one row
//   and one column behind, with its row and column; o_run_end is always 1.
//   Border pixels, and the first frame_width+1 results after reset, give 0.
//   Each accepted pixel is registered in the compare stage and its result
//   in the output register, which drives o_out_valid. Throughput is one
//   pixel per cycle while the receiver does not stall, set by the single
//   read port and the single write port of the line stores, which are read
//   at acceptance and written when the pixel leaves the compare stage.
//   After reset the line stores are zeroed, one entry a cycle, over all
//   MAX_WIDTH entries; o_in_stall is high during that sweep. Config writes
//   (i_cfg_we, i_cfg_index, i_cfg_data) are taken at any time, but are to
//   be made only while no transaction is in flight.
//   When the receiver stalls, the output register holds its result and the
//   compare stage holds one more pixel; beyond that o_in_stall rises.
module local_binary_pattern_3x3 #(
    parameter int MAX_WIDTH = lbp3_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lbp3_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lbp3_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [lbp3_pkg::PIX_W-1:0]           i_pixel,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [lbp3_pkg::PIX_W-1:0]           o_pattern,
    output logic [lbp3_pkg::ROW_W-1:0]           o_out_row,
    output logic [lbp3_pkg::COL_OUT_W-1:0]       o_out_col,
    output logic                                 o_run_end
);
    import lbp3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);       // column index width
    localparam int WW = $clog2(MAX_WIDTH + 1);   // effective width value

    // ---------------- configuration ----------------
    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // frame size saturated into its legal range
    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;

    always_comb begin
        if (32'(r_frame_width) < MIN_DIM) begin
            w_eff = WW'(MIN_DIM);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        if (32'(r_frame_height) < MIN_DIM) begin
            h_eff = ROW_W'(MIN_DIM);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
    end

    // ---------------- handshake ----------------
    logic r_s1_valid;
    logic r_out_valid;
    logic clr_busy;
    logic out_free;
    logic s1_move;
    logic in_accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = clr_busy || (r_s1_valid && !out_free);
    assign in_accept  = i_in_valid && !o_in_stall;

    // ---------------- position of the incoming pixel ----------------
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    logic             col_wrap;
    logic [CW-1:0]    c_cur;
    logic [ROW_W:0]   r_inc;
    logic [ROW_W-1:0] r_cur;
    logic [CW-1:0]    cc;
    logic [ROW_W-1:0] cr;
    logic             interior;
    logic [WW-1:0]    c_nxt;
    logic [ROW_W:0]   r_nxt_inc;
    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;

    always_comb begin
        // a column at or past the width starts the next row
        col_wrap = WW'(r_col) >= w_eff;
        c_cur    = col_wrap ? '0 : r_col;
        r_inc    = (ROW_W+1)'(r_row) + (ROW_W+1)'(col_wrap);
        r_cur    = (r_inc >= (ROW_W+1)'(h_eff)) ? '0 : r_inc[ROW_W-1:0];

        // centre pixel: one row and one column behind, wrapping
        if (c_cur != '0) begin
            cc = c_cur - 1'b1;
            cr = (r_cur != '0) ? r_cur - 1'b1 : h_eff - 1'b1;
        end else begin
            cc = CW'(w_eff - 1'b1);
            if (r_cur >= ROW_W'(2)) begin
                cr = r_cur - ROW_W'(2);
            end else begin
                cr = ROW_W'((ROW_W+1)'(r_cur) + (ROW_W+1)'(h_eff) - (ROW_W+1)'(2));
            end
        end

        interior = (cc != '0) && (WW'(cc) <= w_eff - WW'(2))
                && (cr != '0) && (cr <= h_eff - ROW_W'(2));

        c_nxt     = WW'(c_cur) + 1'b1;
        r_nxt_inc = (ROW_W+1)'(r_cur) + 1'b1;
        if (c_nxt >= w_eff) begin
            n_col = '0;
            n_row = (r_nxt_inc >= (ROW_W+1)'(h_eff)) ? '0 : r_nxt_inc[ROW_W-1:0];
        end else begin
            n_col = c_nxt[CW-1:0];
            n_row = r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- compare stage ----------------
    t_pix             r_s1_px;
    logic [CW-1:0]    r_s1_col;
    logic [CW-1:0]    r_s1_cc;
    logic [ROW_W-1:0] r_s1_cr;
    logic             r_s1_interior;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_px       <= i_pixel;
            r_s1_col      <= c_cur;
            r_s1_cc       <= cc;
            r_s1_cr       <= cr;
            r_s1_interior <= interior;
        end
    end

    t_pix rd_upper;
    t_pix rd_lower;

    // upper store takes the old lower entry, lower store the new pixel
    lbp3_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_accept),
        .i_rd_addr  (c_cur),
        .o_rd_upper (rd_upper),
        .o_rd_lower (rd_lower),
        .i_wr_en    (s1_move),
        .i_wr_addr  (r_s1_col),
        .i_wr_upper (rd_lower),
        .i_wr_lower (r_s1_px),
        .o_busy     (clr_busy)
    );

    // window: entries 0..2 column c-2, 3..5 column c-1 (top, middle, bottom)
    t_pix r_win [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (s1_move) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= rd_upper;
            r_win[4] <= rd_lower;
            r_win[5] <= r_s1_px;
        end
    end

    t_nbrs nbr;
    t_pix  code;

    always_comb begin
        nbr[0] = r_win[0];
        nbr[1] = r_win[3];
        nbr[2] = rd_upper;
        nbr[3] = r_win[1];
        nbr[4] = rd_lower;
        nbr[5] = r_win[2];
        nbr[6] = r_win[5];
        nbr[7] = r_s1_px;
        code   = r_s1_interior ? lbp_code(r_win[4], nbr) : '0;
    end

    // ---------------- output register ----------------
    t_pix                 r_pattern;
    logic [ROW_W-1:0]     r_out_row;
    logic [COL_OUT_W-1:0] r_out_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_pattern <= code;
            r_out_row <= r_s1_cr;
            r_out_col <= COL_OUT_W'(r_s1_cc);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pattern   = r_pattern;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_run_end   = 1'b1;

endmodule
